@@ sv/tcsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsq_pkg
// Shared types and constants for the timed caption show queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsq_pkg;

   localparam int unsigned TIME_W       = 32;
   localparam int unsigned WAIT_W       = 16;
   localparam int unsigned CFG_W        = 23;
   localparam int unsigned DEF_QUEUE_DEPTH  = 64;
   localparam int unsigned DEF_TICKS_PER_MS = 45;

   typedef enum logic [1:0] {
      MODE_SHOW  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_CHECK = 2'd2,
      MODE_FLUSH = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_SHOW_DELAY    = 1'b0,
      CSR_CLEAR_ADVANCE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_POP,
      ST_DONE
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [TIME_W-1:0]  event_time;
      logic [WAIT_W-1:0]  wait_ms;
   } req_type;

   typedef struct packed {
      logic showing;
      logic dropped;
   } rsp_type;

   // One queue entry: command kind (1 = show, 0 = clear) and its due time.
   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] due;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic empty;
      logic full;
   } status_type;

endpackage : tcsq_pkg

`default_nettype wire

@@ sv/tcsq_mem.sv @@
// ----------------------------------------------------------------------------
// tcsq_mem
// Command store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsq_mem #(
   parameter int unsigned QUEUE_DEPTH = tcsq_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [PTR_W-1:0]     wr_addr,
   input  wire tcsq_pkg::entry_type  wr_data,
   input  wire logic                 rd_en,
   input  wire logic [PTR_W-1:0]     rd_addr,
   output tcsq_pkg::entry_type       rd_data
);

   tcsq_pkg::entry_type mem_ff [QUEUE_DEPTH];
   tcsq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : tcsq_mem

`default_nettype wire

@@ sv/tcsq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcsq_ctrl
// Sequencer: due time, queue pointers, pop loop and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsq_ctrl #(
   parameter int unsigned QUEUE_DEPTH  = tcsq_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned TICKS_PER_MS = tcsq_pkg::DEF_TICKS_PER_MS,
   parameter int unsigned PTR_W        = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tcsq_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tcsq_pkg::rsp_type                  rsp_payload,
   input  wire logic [tcsq_pkg::CFG_W-1:0]    show_delay,
   input  wire logic [tcsq_pkg::CFG_W-1:0]    clear_advance,
   output logic                               mem_wr_en,
   output logic [PTR_W-1:0]                   mem_wr_addr,
   output tcsq_pkg::entry_type                mem_wr_data,
   output logic                               mem_rd_en,
   output logic [PTR_W-1:0]                   mem_rd_addr,
   input  wire tcsq_pkg::entry_type           mem_rd_data,
   output tcsq_pkg::status_type               status
);

   localparam int unsigned TW     = tcsq_pkg::TIME_W;
   localparam int unsigned PROD_W = tcsq_pkg::WAIT_W + $clog2(TICKS_PER_MS + 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else                              r = p + PTR_W'(1);
      return r;
   endfunction

   tcsq_pkg::state_type state_ff, state_in;
   tcsq_pkg::req_type   req_ff, req_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TW-1:0]       offset_ff, offset_in;
   logic [PTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic                flag_ff, flag_in;
   logic                drop_ff, drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tcsq_pkg::rsp_type   rsp_ff, rsp_in;

   logic             accept, out_free, load_rsp, reached;
   logic [PTR_W-1:0] head_next, tail_next;
   logic [TW-1:0]    sd_ext, ca_ext, due, age;

   assign accept    = req_valid && (state_ff == tcsq_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_next = next_ptr(head_ff);
   assign tail_next = next_ptr(tail_ff);
   assign sd_ext    = {{(TW - tcsq_pkg::CFG_W){show_delay[tcsq_pkg::CFG_W-1]}}, show_delay};
   assign ca_ext    = {{(TW - tcsq_pkg::CFG_W){clear_advance[tcsq_pkg::CFG_W-1]}},
                       clear_advance};
   assign due       = req_ff.event_time + TW'(prod_ff) + offset_ff;
   // An entry is reached once the wrapped clock minus due time is non-negative.
   assign age       = req_ff.event_time - mem_rd_data.due;
   assign reached   = !age[TW-1];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcsq_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.mode)
                  tcsq_pkg::MODE_SHOW, tcsq_pkg::MODE_CLEAR: state_in = tcsq_pkg::ST_WRITE;
                  tcsq_pkg::MODE_CHECK: begin
                     state_in = (head_ff == tail_ff) ? tcsq_pkg::ST_DONE : tcsq_pkg::ST_POP;
                  end
                  default: state_in = tcsq_pkg::ST_DONE;
               endcase
            end
         end
         tcsq_pkg::ST_WRITE: state_in = tcsq_pkg::ST_DONE;
         tcsq_pkg::ST_POP: begin
            if (!(reached && head_next != tail_ff)) begin
               state_in = tcsq_pkg::ST_DONE;
            end
         end
         tcsq_pkg::ST_DONE: begin
            if (out_free) state_in = tcsq_pkg::ST_IDLE;
         end
         default: state_in = tcsq_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      req_in      = req_ff;
      prod_in     = prod_ff;
      offset_in   = offset_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      flag_in     = flag_ff;
      drop_in     = drop_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = tail_ff;
      mem_wr_data = '{kind: (req_ff.mode == tcsq_pkg::MODE_SHOW), due: due};
      mem_rd_en   = 1'b0;
      mem_rd_addr = head_ff;
      load_rsp    = 1'b0;
      case (state_ff)
         tcsq_pkg::ST_IDLE: begin
            if (accept) begin
               req_in    = req_payload;
               prod_in   = PROD_W'(req_payload.wait_ms) * PROD_W'(TICKS_PER_MS);
               offset_in = (req_payload.mode == tcsq_pkg::MODE_SHOW) ? sd_ext
                                                                     : TW'(0) - ca_ext;
               drop_in   = 1'b0;
               case (req_payload.mode)
                  tcsq_pkg::MODE_CHECK: mem_rd_en = (head_ff != tail_ff);
                  tcsq_pkg::MODE_FLUSH: begin
                     head_in = tail_ff;
                     flag_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         tcsq_pkg::ST_WRITE: begin
            if (tail_next == head_ff) begin
               drop_in = 1'b1;
            end else begin
               mem_wr_en = 1'b1;
               tail_in   = tail_next;
            end
         end
         tcsq_pkg::ST_POP: begin
            if (reached) begin
               flag_in     = mem_rd_data.kind;
               head_in     = head_next;
               mem_rd_en   = (head_next != tail_ff);
               mem_rd_addr = head_next;
            end
         end
         tcsq_pkg::ST_DONE: load_rsp = out_free;
         default: ;
      endcase
      rsp_in       = load_rsp ? '{showing: flag_ff, dropped: drop_ff} : rsp_ff;
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcsq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      prod_ff   <= prod_in;
      offset_ff <= offset_in;
      drop_ff   <= drop_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = (state_ff != tcsq_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign status      = '{busy:  (state_ff != tcsq_pkg::ST_IDLE),
                          empty: (head_ff == tail_ff),
                          full:  (tail_next == head_ff)};

endmodule : tcsq_ctrl

`default_nettype wire

@@ sv/timed_caption_show_queue.sv @@
// ----------------------------------------------------------------------------
// timed_caption_show_queue
// Ring queue of timed show/clear caption commands with a wrap-aware due check.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Transaction
//   req_*     in          req_valid / req_stall   show, clear, check or flush
//   rsp_*     out         rsp_valid / rsp_stall   showing flag and drop flag
//   csr_*     in          csr_valid / csr_ready   show_delay or clear_advance
//
// An event's result is loaded after the write state, a flush's straight from idle;
// a check on a non-empty queue first pops in the pop state, reading one entry per cycle.
// The next transaction can be taken in the cycle after the result is loaded.
// Reset is synchronous and empties the queue; the command memory is not cleared.
// A stalled result holds the sequencer only when a second result is ready to
// load; the result register lets a new transaction be accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_caption_show_queue #(
   parameter int unsigned QUEUE_DEPTH  = tcsq_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned TICKS_PER_MS = tcsq_pkg::DEF_TICKS_PER_MS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire tcsq_pkg::req_type           req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output tcsq_pkg::rsp_type                rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire tcsq_pkg::csr_index_type     csr_index,
   input  wire logic [tcsq_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   // Configuration registers. Both are signed tick offsets; the sequencer
   // sign-extends them to the 32-bit time base.
   logic [tcsq_pkg::CFG_W-1:0] show_delay_ff, show_delay_in;
   logic [tcsq_pkg::CFG_W-1:0] clear_advance_ff, clear_advance_in;

   logic                 mem_wr_en, mem_rd_en;
   logic [PTR_W-1:0]     mem_wr_addr, mem_rd_addr;
   tcsq_pkg::entry_type  mem_wr_data, mem_rd_data;
   tcsq_pkg::status_type status;

   // Always taken; the user must change configuration only while idle; not enforced.
   assign csr_ready = 1'b1;

   always_comb begin
      show_delay_in    = show_delay_ff;
      clear_advance_in = clear_advance_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tcsq_pkg::CSR_SHOW_DELAY:    show_delay_in    = csr_wdata;
            tcsq_pkg::CSR_CLEAR_ADVANCE: clear_advance_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         show_delay_ff    <= '0;
         clear_advance_ff <= '0;
      end else begin
         show_delay_ff    <= show_delay_in;
         clear_advance_ff <= clear_advance_in;
      end
   end

   // The sequencer owns the head and tail pointers and the show flag. It is the
   // only user of the memory and never writes and reads in overlapping steps:
   // a write happens only while handling an event, and reads only during a
   // check, so no forwarding path is needed.
   tcsq_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TICKS_PER_MS (TICKS_PER_MS),
      .PTR_W        (PTR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .show_delay    (show_delay_ff),
      .clear_advance (clear_advance_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .status        (status)
   );

   // Command kind and due time share one entry of a single memory.
   tcsq_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef ASSERT_OFF
   // A new transaction only enters when the sequencer has finished the last one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.busy)
      else $error("request accepted while sequencer busy");

   // The queue can never look empty and full at the same time.
   assert property (@(posedge clock) disable iff (reset)
      !(status.empty && status.full))
      else $error("queue pointers inconsistent");

   // A new result only appears after the sequencer has worked on a transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.busy))
      else $error("result produced without a transaction");

   // The memory is never written while an entry is being read for a pop.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory write overlaps a pop read");
`endif

endmodule : timed_caption_show_queue

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the timed caption show queue.
// A short directed run covers timestamp wrap, the half-range due boundary,
// multi-entry pops, empty checks and flushes. Random traffic then follows a
// running 45 kHz clock through several delay settings, and fills the queue
// until events are dropped. A scoreboard class keeps its own copy of the ring
// queue and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUEUE_SLOTS = tcsq_pkg::DEF_QUEUE_DEPTH;
   localparam int unsigned TICKS       = tcsq_pkg::DEF_TICKS_PER_MS;
   localparam int unsigned CFG_W       = tcsq_pkg::CFG_W;
   localparam int unsigned PHASES      = 6;
   localparam int unsigned PHASE_ITEMS = 213;

   // Scoreboard: a ring queue of due times that mirrors the block's queue,
   // plus a FIFO of the results that the accepted transactions must produce.
   class caption_scoreboard;
      bit                kind_mem [QUEUE_SLOTS];
      logic [31:0]       due_mem [QUEUE_SLOTS];
      int unsigned       head;
      int unsigned       tail;
      bit                flag;
      logic [CFG_W-1:0]  show_delay;
      logic [CFG_W-1:0]  clear_advance;
      tcsq_pkg::rsp_type expected_q [$];
      int unsigned       errors;
      int unsigned       requests;
      int unsigned       responses;
      int unsigned       drops;
      int unsigned       pops;
      int unsigned       peak_fill;

      function new();
         head          = 0;
         tail          = 0;
         flag          = 0;
         show_delay    = '0;
         clear_advance = '0;
      endfunction

      function void set_register(tcsq_pkg::csr_index_type idx, logic [CFG_W-1:0] value);
         if (idx == tcsq_pkg::CSR_SHOW_DELAY) begin
            show_delay = value;
         end else begin
            clear_advance = value;
         end
      endfunction

      function logic [31:0] sign_extend(logic [CFG_W-1:0] value);
         return {{(32-CFG_W){value[CFG_W-1]}}, value};
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Applies one accepted transaction to the mirrored queue and records
      // the result it must produce.
      function void note_request(tcsq_pkg::req_type r);
         logic [31:0]       due;
         logic [31:0]       diff;
         tcsq_pkg::rsp_type e;
         int unsigned       fill;
         e.dropped = 1'b0;
         case (r.mode)
            tcsq_pkg::MODE_SHOW, tcsq_pkg::MODE_CLEAR: begin
               due = r.event_time + 32'(r.wait_ms) * TICKS;
               if (r.mode == tcsq_pkg::MODE_SHOW) begin
                  due += sign_extend(show_delay);
               end else begin
                  due -= sign_extend(clear_advance);
               end
               if ((tail + 1) % QUEUE_SLOTS == head) begin
                  e.dropped = 1'b1;
                  drops++;
               end else begin
                  kind_mem[tail] = (r.mode == tcsq_pkg::MODE_SHOW);
                  due_mem[tail]  = due;
                  tail           = (tail + 1) % QUEUE_SLOTS;
               end
            end
            tcsq_pkg::MODE_CHECK: begin
               // An entry is due once the wrapped difference is non-negative.
               while (head != tail) begin
                  diff = r.event_time - due_mem[head];
                  if (diff[31]) break;
                  flag = kind_mem[head];
                  head = (head + 1) % QUEUE_SLOTS;
                  pops++;
               end
            end
            tcsq_pkg::MODE_FLUSH: begin
               head = tail;
               flag = 1'b0;
            end
            default: ;
         endcase
         e.showing = flag;
         expected_q = {expected_q, e};
         requests++;
         fill = (tail + QUEUE_SLOTS - head) % QUEUE_SLOTS;
         if (fill > peak_fill) peak_fill = fill;
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(tcsq_pkg::rsp_type r);
         tcsq_pkg::rsp_type e;
         responses++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", responses));
            return;
         end
         e = expected_q.pop_front();
         if (r.showing !== e.showing)
            report_mismatch($sformatf("result %0d showing is %b, expected %b",
                                      responses, r.showing, e.showing));
         if (r.dropped !== e.dropped)
            report_mismatch($sformatf("result %0d dropped is %b, expected %b",
                                      responses, r.dropped, e.dropped));
      endtask
   endclass

   // Every input of the block starts at a known value.
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   tcsq_pkg::req_type       req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   tcsq_pkg::rsp_type       rsp_payload;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   tcsq_pkg::csr_index_type csr_index   = tcsq_pkg::CSR_SHOW_DELAY;
   logic [CFG_W-1:0]        csr_wdata   = '0;

   caption_scoreboard board = new();

   int unsigned sent          = 0;
   int unsigned gap_pct       = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned rsp_burst     = 0;
   logic [31:0] clk_now       = '0;

   timed_caption_show_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitors sample at the rising edge, so they see the values that the
   // block itself sees when a transaction is accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_payload);
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
   end

   // The receiver stalls in bursts of random length. A percentage of
   // zero gives a stretch with no stalls at all.
   always @(posedge clock) begin
      if (reset || rsp_stall_pct == 0) begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
      end else if (rsp_burst > 1) begin
         rsp_burst <= rsp_burst - 1;
      end else if ($urandom_range(1, 100) <= rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(1, 15);
      end else begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
      end
   end

   function automatic tcsq_pkg::req_type make_item(tcsq_pkg::mode_type m, logic [31:0] t,
                                                   logic [15:0] w);
      tcsq_pkg::req_type r;
      r.mode       = m;
      r.event_time = t;
      r.wait_ms    = w;
      return r;
   endfunction

   // Presents one transaction and returns after the edge that accepts it.
   // Valid stays high on return; the next caller either reuses it or drops it.
   task automatic drive_item(tcsq_pkg::req_type r);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_payload <= r;
      req_valid   <= 1'b1;
      sent++;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every outstanding result has been taken.
   // The task always waits for a clock edge, so valid is never lowered and raised together.
   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Writes both delay registers; the block is idle when this is called.
   task automatic write_registers(logic [CFG_W-1:0] delay, logic [CFG_W-1:0] advance);
      csr_valid <= 1'b1;
      csr_index <= tcsq_pkg::CSR_SHOW_DELAY;
      csr_wdata <= delay;
      do @(posedge clock); while (!csr_ready);
      board.set_register(tcsq_pkg::CSR_SHOW_DELAY, delay);
      csr_index <= tcsq_pkg::CSR_CLEAR_ADVANCE;
      csr_wdata <= advance;
      do @(posedge clock); while (!csr_ready);
      board.set_register(tcsq_pkg::CSR_CLEAR_ADVANCE, advance);
      csr_valid <= 1'b0;
   endtask

   // A show or clear event a little ahead of the running clock. Most waits
   // are short, as real captions are; some span the whole field.
   task automatic send_event(bit is_show);
      logic [15:0] w;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         w = 16'($urandom_range(0, 300));
      end else if (pick < 9) begin
         w = 16'($urandom_range(0, 65535));
      end else begin
         w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      drive_item(make_item(is_show ? tcsq_pkg::MODE_SHOW : tcsq_pkg::MODE_CLEAR,
                           clk_now + $urandom_range(0, 45000), w));
   endtask

   // A stretch of events interleaved with checks as the clock moves forward.
   // Now and then the clock jumps by a random amount, wrapping past zero.
   task automatic timeline(int unsigned count);
      logic [31:0] advance;
      repeat (count) begin
         if ($urandom_range(0, 99) < 55) begin
            send_event($urandom_range(0, 1));
         end else begin
            advance = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60000);
            clk_now += advance;
            drive_item(make_item(tcsq_pkg::MODE_CHECK, clk_now, 16'($urandom())));
         end
      end
   endtask

   task automatic run_random(int unsigned target, bit quiet);
      int unsigned stop;
      int unsigned pick;
      stop = sent + target;
      while (sent < stop) begin
         // Idling is chosen per sequence, so some sequences run at full rate.
         if (quiet || $urandom_range(0, 3) == 0) begin
            gap_pct        = 0;
            rsp_stall_pct <= 0;
         end else begin
            gap_pct        = $urandom_range(5, 40);
            rsp_stall_pct <= $urandom_range(5, 40);
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            timeline($urandom_range(2, 12));
         end else if (pick < 65) begin
            // Push up to and past the queue's capacity so events can be dropped, then
            // drain it either by a check far ahead or by a flush.
            repeat ($urandom_range(50, 75)) send_event($urandom_range(0, 1));
            if ($urandom_range(0, 1)) begin
               clk_now += 32'h1000_0000;
               drive_item(make_item(tcsq_pkg::MODE_CHECK, clk_now, 16'($urandom())));
            end else begin
               drive_item(make_item(tcsq_pkg::MODE_FLUSH, $urandom(), 16'($urandom())));
            end
         end else if (pick < 77) begin
            // Unstructured transactions with every field random.
            repeat ($urandom_range(1, 6))
               drive_item(make_item(tcsq_pkg::mode_type'($urandom_range(0, 3)), $urandom(),
                                    16'($urandom())));
         end else if (pick < 83) begin
            drive_item(make_item(tcsq_pkg::MODE_FLUSH, $urandom(), 16'($urandom())));
         end else if (pick < 88) begin
            pause_sender();
         end else begin
            // Park the clock just below the wrap point and keep going.
            clk_now = 32'hFFFF_FFFF - $urandom_range(0, 400000);
            timeline($urandom_range(4, 12));
         end
      end
   endtask

   // Directed cases, run with both registers at their reset value of zero.
   task automatic run_directed();
      gap_pct        = 20;
      rsp_stall_pct <= 20;
      // Check on an empty queue.
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h0, 16'h0));
      // Due exactly at zero, reached on the same tick.
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'h0, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h0, 16'h0));
      // Due time wraps past zero: not yet reached, then reached right at due.
      drive_item(make_item(tcsq_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'hFFFF_FFFF, 16'hFFFF));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h002C_FFD2, 16'h0));
      // One tick early, then on time.
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'd100, 16'd1));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'd144, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'd145, 16'h0));
      // Pops three, the last a clear; then the largest distance still due.
      drive_item(make_item(tcsq_pkg::MODE_CLEAR, 32'h1000, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'h2000, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CLEAR, 32'h3000, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'h4000, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h3800, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h8000_3FFF, 16'h0));
      // Half the range away counts as still ahead.
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'h0, 16'h0));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h8000_0000, 16'h0));
      // Flush with entries held; the queue is empty again afterwards.
      drive_item(make_item(tcsq_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 16'hFFFF));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h8000_0000, 16'h0));
      // Still ahead after the wrap.
      drive_item(make_item(tcsq_pkg::MODE_SHOW,  32'hFFFF_FFFF, 16'hFFFF));
      drive_item(make_item(tcsq_pkg::MODE_CHECK, 32'h0, 16'hFFFF));
      drive_item(make_item(tcsq_pkg::MODE_FLUSH, 32'h0, 16'h0));
   endtask

   // Register settings per phase: the ends of the usual range and the extremes
   // of the 23-bit field, each both ways round, one random pair, and zero.
   logic [CFG_W-1:0] delay_set   [PHASES] = '{23'(2700000), 23'h3F_FFFF, 23'h40_0000,
                                              23'h0, 23'(-2700000), 23'h0};
   logic [CFG_W-1:0] advance_set [PHASES] = '{23'(-2700000), 23'h40_0000, 23'h3F_FFFF,
                                              23'h0, 23'(2700000), 23'h0};

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();

      delay_set[3]   = 23'($urandom());
      advance_set[3] = 23'($urandom());
      for (int p = 0; p < PHASES; p++) begin
         // Registers change only while nothing is in flight.
         pause_sender();
         write_registers(delay_set[p], advance_set[p]);
         run_random(PHASE_ITEMS, p == PHASES - 1);
      end

      // All stimulus is in: wait for the last results, then leave room for
      // a stray result to show up.
      pause_sender();
      repeat (100) @(posedge clock);

      $display("Ran %0d transactions over %0d register settings; %0d results checked.",
               board.requests, PHASES + 1, board.responses);
      $display("Popped %0d commands, dropped %0d events on a full queue, peak fill %0d.",
               board.pops, board.drops, board.peak_fill);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("timed_caption_show_queue: match");
      end else begin
         $display("timed_caption_show_queue: mismatch");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Timed out with %0d results outstanding.", board.pending());
      $display("timed_caption_show_queue: mismatch");
      $finish;
   end

endmodule
